// ===== hdl/skim_pkg.sv =====
// Package for the sorted key to index map: sizes, codes and controller types.
package skim_pkg;
  localparam int Capacity = 1024;
  localparam int KeyWidth = 64;
  localparam int AddrW = $clog2(Capacity);
  localparam int CountW = $clog2(Capacity + 1);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_INSERT_IX = 2'd1;
  localparam logic [1:0] KIND_FIND = 2'd2;

  localparam logic [2:0] ST_NEW = 3'd0;
  localparam logic [2:0] ST_EXISTS = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_FOUND = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_PLACE, S_SCAN_RD, S_SCAN_CMP, S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic place_wr;
    logic scan_init;
    logic scan_rd;
    logic scan_step;
    logic set_result;
    logic [2:0] result_status;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] kind;
    logic srch_active;
    logic srch_hit;
    logic key_match;
    logic full;
    logic shift_active;
    logic scan_active;
    logic scan_hit;
  } stat_t;
endpackage

// ===== hdl/sorted_key_to_index_map.sv =====
// Top level of the sorted key to index map.
// The block keeps up to 1024 keys in ascending unsigned order in a store with
// one read port, each with a 16-bit index, and handles one transfer at a time.
// An insert binary-searches the key, then moves every entry above the
// insertion point up one place; a plain insert refuses a key that is already
// stored, while an insert with a given index may add a duplicate key.
// A find by index walks the entries from the lowest key. Search, shift and
// scan all share the read port of the store. The result is held until its
// transfer completes, and the next input is taken after that. The max_entries
// register caps the entry count; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module sorted_key_to_index_map import skim_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] key,
  input  logic [15:0] index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] result_index,
  output logic [63:0] result_key,
  output logic [10:0] entry_total
);
  cmd_t  cmd;
  stat_t stat;

  skim_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  skim_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_data,
    .in_kind(kind), .in_key(key), .in_index(index),
    .status, .result_index, .result_key, .entry_total
  );
endmodule

// ===== hdl/skim_datapath.sv =====
// Datapath: key and index stores, search bounds, shift and scan pointers.
module skim_datapath import skim_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_data,
  input  logic [1:0]          in_kind,
  input  logic [63:0]         in_key,
  input  logic [15:0]         in_index,
  output logic [2:0]          status,
  output logic [15:0]         result_index,
  output logic [63:0]         result_key,
  output logic [10:0]         entry_total
);
  logic [KeyWidth-1:0] key_mem [Capacity];
  logic [15:0] ix_mem [Capacity];

  logic [1:0] kind;
  logic [KeyWidth-1:0] key;
  logic [15:0] index;
  logic [10:0] max_entries;
  logic [CountW-1:0] count;
  logic [CountW-1:0] lo, hi, ptr;
  logic [KeyWidth-1:0] rd_key;
  logic [15:0] rd_ix;
  logic hit;
  logic [CountW-1:0] mid;
  logic [CountW:0] mid_sum;
  logic [CountW-1:0] limit;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CountW:1];
  assign limit = (int'(max_entries) < Capacity) ? CountW'(max_entries) : CountW'(Capacity);

  // Reads: one registered port serves search, shift and scan.
  logic [AddrW-1:0] rd_addr;
  always_comb begin
    if (cmd.shift_rd) rd_addr = AddrW'(ptr - 1'b1);
    else if (cmd.scan_rd) rd_addr = ptr[AddrW-1:0];
    else rd_addr = mid[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_ix <= ix_mem[rd_addr];
    if (cmd.shift_wr) begin
      key_mem[ptr[AddrW-1:0]] <= rd_key;
      ix_mem[ptr[AddrW-1:0]] <= rd_ix;
    end else if (cmd.place_wr) begin
      key_mem[lo[AddrW-1:0]] <= key;
      ix_mem[lo[AddrW-1:0]] <= (kind == KIND_INSERT) ? 16'(count) : index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      max_entries <= 11'd1024;
      hit <= 1'b0;
    end else begin
      if (cfg_we) max_entries <= cfg_data;
      if (cmd.place_wr) count <= count + 1'b1;
      if (cmd.srch_init) hit <= 1'b0;
      else if (cmd.srch_step && rd_key == key) hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      key <= in_key[KeyWidth-1:0];
      index <= in_index;
    end
    if (cmd.srch_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.srch_step) begin
      if (rd_key == key) lo <= mid;
      else if (key < rd_key) hi <= mid;
      else lo <= mid + 1'b1;
      if (rd_key == key) hi <= mid;
    end
    if (cmd.shift_init) ptr <= count;
    else if (cmd.shift_wr) ptr <= ptr - 1'b1;
    else if (cmd.scan_init) ptr <= '0;
    else if (cmd.scan_step) ptr <= ptr + 1'b1;
    if (cmd.set_result) begin
      status <= cmd.result_status;
      entry_total <= 11'(cmd.place_wr ? count + 1'b1 : count);
      result_key <= '0;
      case (cmd.result_status)
        ST_NEW: result_index <= (kind == KIND_INSERT) ? 16'(count) : index;
        ST_EXISTS: result_index <= rd_ix;
        ST_FOUND: begin
          result_index <= index;
          result_key <= 64'(rd_key);
        end
        default: result_index <= '0;
      endcase
    end
  end

  always_comb begin
    stat.kind = kind;
    stat.srch_active = (lo < hi) && !hit;
    stat.srch_hit = hit;
    stat.key_match = (rd_key == key);
    stat.full = (count >= limit);
    stat.shift_active = (ptr > lo);
    stat.scan_active = (ptr < count);
    stat.scan_hit = (rd_ix == index);
  end
endmodule

// ===== hdl/skim_ctrl.sv =====
// Controller state machine sequencing search, shift, place and scan.
module skim_ctrl import skim_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_SRCH_RD;
      S_SRCH_RD: begin
        if (stat.kind == KIND_FIND) state_next = S_SCAN_RD;
        else if (!(stat.kind inside {KIND_INSERT, KIND_INSERT_IX}))
          state_next = S_DONE;
        else if (stat.srch_active) state_next = S_SRCH_CMP;
        else state_next = S_DECIDE;
      end
      S_SRCH_CMP: state_next = S_SRCH_RD;
      S_DECIDE: begin
        if (stat.kind == KIND_INSERT && stat.srch_hit) state_next = S_DONE;
        else if (stat.full) state_next = S_DONE;
        else state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_next = stat.shift_active ? S_SHIFT_WR : S_PLACE;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_PLACE: state_next = S_DONE;
      S_SCAN_RD: state_next = stat.scan_active ? S_SCAN_CMP : S_DONE;
      S_SCAN_CMP: state_next = stat.scan_hit ? S_DONE : S_SCAN_RD;
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == S_IDLE);
    out_valid = (state == S_DONE);
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.srch_init = in_valid;
      end
      S_SRCH_RD: begin
        cmd.srch_rd = 1'b1;
        if (stat.kind == KIND_FIND) cmd.scan_init = 1'b1;
        else if (!(stat.kind inside {KIND_INSERT, KIND_INSERT_IX})) begin
          cmd.set_result = 1'b1;
          cmd.result_status = ST_MISSING;
        end
      end
      S_SRCH_CMP: cmd.srch_step = 1'b1;
      S_DECIDE: begin
        if (stat.kind == KIND_INSERT && stat.srch_hit) begin
          cmd.set_result = 1'b1;
          cmd.result_status = ST_EXISTS;
        end else if (stat.full) begin
          cmd.set_result = 1'b1;
          cmd.result_status = ST_FULL;
        end else cmd.shift_init = 1'b1;
      end
      S_SHIFT_RD: cmd.shift_rd = 1'b1;
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_PLACE: begin
        cmd.place_wr = 1'b1;
        cmd.set_result = 1'b1;
        cmd.result_status = ST_NEW;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        if (!stat.scan_active) begin
          cmd.set_result = 1'b1;
          cmd.result_status = ST_MISSING;
        end
      end
      S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          cmd.set_result = 1'b1;
          cmd.result_status = ST_FOUND;
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== sim/tb_sorted_key_to_index_map.sv =====
// Testbench for the sorted key to index map: random and directed table traffic.
`timescale 1ns / 1ps

module tb_sorted_key_to_index_map;
  import skim_pkg::*;

  // The fourth kind code is unused by the block; it must leave the table alone.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [15:0] idx;
  } map_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] rindex;
    logic [63:0] rkey;
    logic [10:0] total;
  } map_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [63:0] key = '0;
  logic [15:0] index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] result_index;
  logic [63:0] result_key;
  logic [10:0] entry_total;

  sorted_key_to_index_map dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .key(key), .index(index),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .result_index(result_index), .result_key(result_key), .entry_total(entry_total)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table, kept sorted exactly as the block keeps it.
  logic [63:0] shadow_keys [Capacity];
  logic [15:0] shadow_ix [Capacity];
  int          shadow_count = 0;
  int          shadow_limit = 1024;

  map_req_t    pending_reqs[$];
  map_reply_t  expected_replies[$];
  logic [63:0] key_pool[$];

  int  traffic_mode = 0;     // 0 none, 1 sender idle, 2 receiver stall, 3 both light
  int  hold_cycles = 0;      // long receiver hold-off, counted down by the receiver
  bit  took_req = 1'b0;
  int  errors = 0;
  int  checked = 0;
  int  status_seen [5];

  // Binary search; on a hit it returns the probe that met the key, which decides
  // which of two duplicate entries an insert reports.
  function automatic int search_slot(logic [63:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (k == shadow_keys[mid]) return mid;
      if (k < shadow_keys[mid]) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic void shift_in(int pos, logic [63:0] k, logic [15:0] ix);
    for (int i = shadow_count; i > pos; i--) begin
      shadow_keys[i] = shadow_keys[i-1];
      shadow_ix[i] = shadow_ix[i-1];
    end
    shadow_keys[pos] = k;
    shadow_ix[pos] = ix;
    shadow_count++;
  endfunction

  function automatic map_reply_t table_update(map_req_t r);
    map_reply_t rep;
    int pos, lim;
    rep = '{status: ST_MISSING, rindex: '0, rkey: '0, total: '0};
    lim = (shadow_limit < Capacity) ? shadow_limit : Capacity;
    case (r.kind)
      KIND_INSERT: begin
        pos = search_slot(r.key);
        if (pos < shadow_count && shadow_keys[pos] == r.key) begin
          rep.status = ST_EXISTS;
          rep.rindex = shadow_ix[pos];
        end else if (shadow_count >= lim) begin
          rep.status = ST_FULL;
        end else begin
          rep.status = ST_NEW;
          rep.rindex = 16'(shadow_count);
          shift_in(pos, r.key, 16'(shadow_count));
        end
      end
      KIND_INSERT_IX: begin
        // No duplicate check here: an equal key is simply placed beside the equal key the search meets.
        pos = search_slot(r.key);
        if (shadow_count >= lim) begin
          rep.status = ST_FULL;
        end else begin
          shift_in(pos, r.key, r.idx);
          rep.status = ST_NEW;
          rep.rindex = r.idx;
        end
      end
      KIND_FIND: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_ix[i] == r.idx) begin
            rep.status = ST_FOUND;
            rep.rindex = r.idx;
            rep.rkey = shadow_keys[i];
            break;
          end
        end
      end
      default: ;
    endcase
    rep.total = 11'(shadow_count);
    return rep;
  endfunction

  // Input side: predict every accepted request at the edge where it transfers.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_replies.push_back(table_update('{kind: kind, key: key, idx: index}));
      took_req = 1'b1;
    end
  end

  // Driver: offers the next pending request, holding it until it transfers.
  always @(negedge clk) begin
    map_req_t r;
    bit idle;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took_req) begin
      took_req = 1'b0;
      idle = (traffic_mode == 1) ? ($urandom_range(99) < 56) :
             (traffic_mode == 3) ? ($urandom_range(99) < 8) : 1'b0;
      if (pending_reqs.size() > 0 && !idle) begin
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        kind <= r.kind;
        key <= r.key;
        index <= r.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls by mode, plus the long hold-off when one is armed.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (traffic_mode == 2) begin
      out_ready <= ($urandom_range(99) >= 56);
    end else if (traffic_mode == 3) begin
      out_ready <= ($urandom_range(99) >= 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin
    map_reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%0d key=%h total=%0d",
                 $time, status, result_index, result_key, entry_total);
        errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        checked++;
        if (exp_r.status < 5) status_seen[exp_r.status]++;
        if (status !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, status);
          errors++;
        end
        if (result_index !== exp_r.rindex) begin
          $display("%0t: result_index expected %0d got %0d", $time, exp_r.rindex,
                   result_index);
          errors++;
        end
        if (result_key !== exp_r.rkey) begin
          $display("%0t: result_key expected %h got %h", $time, exp_r.rkey, result_key);
          errors++;
        end
        if (entry_total !== exp_r.total) begin
          $display("%0t: entry_total expected %0d got %0d", $time, exp_r.total,
                   entry_total);
          errors++;
        end
      end
    end
  end

  function automatic logic [63:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (key_pool.size() > 0 && roll < 35) return key_pool[$urandom_range(key_pool.size()-1)];
    if (roll < 40) return '1;
    if (roll < 44) return '0;
    if (roll < 48) return 64'h8000_0000_0000_0000;
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(logic [1:0] k, logic [63:0] kv, logic [15:0] ix);
    pending_reqs.push_back('{kind: k, key: kv, idx: ix});
    if (k == KIND_INSERT || k == KIND_INSERT_IX) key_pool.push_back(kv);
  endfunction

  function automatic void queue_random(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 50)
        queue_req(KIND_INSERT, pick_key(), 16'($urandom));
      else if (roll < 65)
        queue_req(KIND_INSERT_IX, pick_key(),
                  ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(shadow_count + 4)));
      else if (roll < 95)
        queue_req(KIND_FIND, 64'({$urandom, $urandom}),
                  ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(shadow_count + 4)));
      else
        queue_req(KIND_SPARE, {$urandom, $urandom}, 16'($urandom));
    end
  endfunction

  // The register may only change while the block has nothing in flight.
  task automatic set_limit(int lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= 11'(lim);
    shadow_limit = lim;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Checked at rising edges, where the driver never changes its outputs.
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Limit of zero: every insert is refused, the table stays empty.
    set_limit(0);
    traffic_mode = 0;
    queue_req(KIND_INSERT, '0, '0);
    queue_req(KIND_INSERT_IX, '1, '1);
    queue_req(KIND_FIND, '0, '0);
    queue_req(KIND_SPARE, '1, '1);
    drain();

    // Limit of one: a single entry, then existing-key and full paths.
    set_limit(1);
    queue_req(KIND_INSERT, '0, 16'h1234);
    queue_req(KIND_INSERT, '0, '0);
    queue_req(KIND_INSERT, 64'd5, '0);
    queue_req(KIND_INSERT_IX, 64'd5, 16'h00FF);
    queue_req(KIND_FIND, '1, '0);
    queue_req(KIND_FIND, '0, 16'd1);
    drain();

    // Small table: duplicate key through the given-index path, extreme keys.
    set_limit(8);
    queue_req(KIND_INSERT_IX, '0, '1);
    queue_req(KIND_INSERT, '0, '0);
    queue_req(KIND_INSERT, '1, '0);
    queue_req(KIND_INSERT, 64'h8000_0000_0000_0000, '0);
    queue_req(KIND_FIND, '0, '1);
    queue_req(KIND_INSERT_IX, 64'd7, '0);
    queue_req(KIND_INSERT, 64'd3, '0);
    queue_req(KIND_FIND, '0, 16'd3);
    queue_req(KIND_SPARE, '0, '0);
    queue_req(KIND_FIND, '0, 16'hFFFE);
    drain();

    set_limit(24);
    traffic_mode = 1;
    queue_random(90);
    drain();

    // Above capacity the effective limit is the capacity itself. The receiver
    // holds off at the start so the block keeps a result and stops taking input.
    set_limit(2047);
    traffic_mode = 0;
    hold_cycles = 400;
    queue_random(100);
    drain();

    set_limit(1024);
    traffic_mode = 2;
    queue_random(90);
    drain();

    set_limit(2047);
    traffic_mode = 3;
    queue_random(100);
    drain();

    set_limit(16);
    traffic_mode = 1;
    queue_random(60);
    drain();

    set_limit(300);
    traffic_mode = 0;
    queue_random(120);
    drain();

    $display("Checked %0d results: %0d new, %0d existing, %0d full, %0d found, %0d missing;",
             checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    $display("table ended with %0d entries across limits from zero past capacity.",
             shadow_count);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out with %0d results outstanding.", expected_replies.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/skim_pkg.sv
hdl/skim_datapath.sv
hdl/skim_ctrl.sv
hdl/sorted_key_to_index_map.sv
sim/tb_sorted_key_to_index_map.sv
